[rtl/assert_macros.svh]
// Assertion macros shared by the codec RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ESCC_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed: invariant");

// Check that a trigger is followed by a consequence in the next cycle.
`define ESCC_ASSERT_NEXT(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/escc_pkg.sv]
// Types and constants for the escape sequence codec.
// No dependencies; imported by all codec modules.
`timescale 1ns / 1ps

package escc_pkg;

	localparam int unsigned MaxRes = 4;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_BSL   = 2'd1,
		PH_OCT   = 2'd2,
		PH_CARET = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] oval;
		logic [1:0] ocnt;
		logic       hbs;
	} codec_state_t;

	typedef struct packed {
		logic [MaxRes-1:0][7:0] data;
		logic [2:0]             cnt;
	} res_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ESC   = 8'd27;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LE    = 8'h65;
	localparam logic [7:0] CH_LF_L  = 8'h66;
	localparam logic [7:0] CH_LN    = 8'h6E;
	localparam logic [7:0] CH_LR    = 8'h72;
	localparam logic [7:0] CH_LT    = 8'h74;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] WC_QMARK = 8'd191;
	localparam logic [7:0] WC_LBRK  = 8'd219;
	localparam logic [7:0] WC_STAR  = 8'd170;
	localparam logic [7:0] CTRL_OFS = 8'd64;
	localparam logic [7:0] CASE_OFS = 8'd32;
	localparam logic [7:0] HIGH_BIT = 8'h80;

	function automatic logic is_octal(input logic [7:0] b);
		return b[7:3] == 5'b00110;
	endfunction

endpackage

[rtl/escc_xlate.sv]
// Single-pass translation of one byte into up to four result bytes.
// Depends on escc_pkg; pure combinational logic.
`timescale 1ns / 1ps

module escc_xlate (
	input  logic                  dir,
	input  escc_pkg::codec_state_t cur,
	input  logic [7:0]            byte_in,
	output escc_pkg::codec_state_t nxt,
	output escc_pkg::res_t         res
);
	import escc_pkg::*;

	localparam codec_state_t ST_CLEAR = '{phase: PH_IDLE, oval: 8'd0, ocnt: 2'd0, hbs: 1'b0};

	logic [7:0] oct_acc;
	logic [7:0] up_c;
	logic       is_lower;
	logic       is_upper;

	assign oct_acc  = {cur.oval[4:0], 3'b000} + {5'd0, byte_in[2:0]};
	assign is_lower = (byte_in >= 8'd97) && (byte_in <= 8'd122);
	assign up_c     = is_lower ? (byte_in - CASE_OFS) : byte_in;
	assign is_upper = (up_c >= 8'd65) && (up_c <= 8'd90);

	// Next state
	always_comb begin
		nxt = cur;
		if (byte_in == CH_NUL) begin
			nxt = ST_CLEAR;
		end else if (dir) begin
			if ((byte_in[7]) && (byte_in != WC_QMARK) && (byte_in != WC_LBRK)
					&& (byte_in != WC_STAR)) begin
				nxt.hbs = 1'b1;
			end
		end else begin
			unique case (cur.phase)
				PH_IDLE: begin
					if (byte_in == CH_BSL) nxt.phase = PH_BSL;
					else if (byte_in == CH_CARET) nxt.phase = PH_CARET;
				end
				PH_BSL: begin
					nxt.phase = PH_IDLE;
					if (byte_in == CH_LE || byte_in == CH_LT || byte_in == CH_LF_L
							|| byte_in == CH_LR || byte_in == CH_LN || byte_in == CH_LB
							|| byte_in == CH_BSL || byte_in == CH_STAR
							|| byte_in == CH_QMARK || byte_in == CH_LBRK) begin
						nxt.phase = PH_IDLE;
					end else if (is_octal(byte_in)) begin
						nxt.oval  = {5'd0, byte_in[2:0]};
						nxt.ocnt  = 2'd1;
						nxt.phase = PH_OCT;
					end else if (byte_in == CH_CARET) begin
						nxt.phase = PH_CARET;
					end
				end
				PH_OCT: begin
					nxt.oval  = 8'd0;
					nxt.ocnt  = 2'd0;
					nxt.phase = PH_IDLE;
					if (is_octal(byte_in) && cur.ocnt == 2'd1) begin
						nxt.oval  = oct_acc;
						nxt.ocnt  = 2'd2;
						nxt.phase = PH_OCT;
					end else if (!is_octal(byte_in)) begin
						if (byte_in == CH_BSL) nxt.phase = PH_BSL;
						else if (byte_in == CH_CARET) nxt.phase = PH_CARET;
					end
				end
				PH_CARET: nxt.phase = PH_IDLE;
				default: nxt.phase = PH_IDLE;
			endcase
		end
	end

	// Result bytes
	always_comb begin
		res.data = '0;
		res.cnt  = 3'd0;
		if (dir) begin
			case (byte_in)
				CH_NUL: begin
					res.data[0] = CH_NUL; res.cnt = 3'd1;
				end
				CH_ESC: begin
					res.data[0] = CH_BSL; res.data[1] = CH_LE; res.cnt = 3'd2;
				end
				CH_LF: begin
					res.data[0] = CH_BSL; res.data[1] = CH_LN; res.cnt = 3'd2;
				end
				CH_FF: begin
					res.data[0] = CH_BSL; res.data[1] = CH_LF_L; res.cnt = 3'd2;
				end
				CH_CR: begin
					res.data[0] = CH_BSL; res.data[1] = CH_LR; res.cnt = 3'd2;
				end
				CH_TAB: begin
					res.data[0] = CH_BSL; res.data[1] = CH_LT; res.cnt = 3'd2;
				end
				CH_BSL: begin
					res.data[0] = CH_BSL; res.data[1] = CH_BSL; res.cnt = 3'd2;
				end
				WC_QMARK, WC_LBRK, WC_STAR: begin
					if (cur.hbs) begin
						res.data[0] = byte_in; res.cnt = 3'd1;
					end else begin
						res.data[0] = CH_BSL;
						res.data[1] = byte_in & CH_DEL;
						res.cnt     = 3'd2;
					end
				end
				CH_DEL: begin
					res.data[0] = CH_BSL; res.data[1] = CH_ONE;
					res.data[2] = CH_SEVEN; res.data[3] = CH_SEVEN;
					res.cnt = 3'd4;
				end
				default: begin
					if (byte_in[7] || byte_in < CH_SPACE) begin
						res.data[0] = CH_CARET;
						res.data[1] = byte_in + CTRL_OFS;
						res.cnt     = 3'd2;
					end else begin
						res.data[0] = byte_in; res.cnt = 3'd1;
					end
				end
			endcase
		end else begin
			unique case (cur.phase)
				PH_IDLE: begin
					if (byte_in != CH_BSL && byte_in != CH_CARET) begin
						res.data[0] = byte_in; res.cnt = 3'd1;
					end
				end
				PH_BSL: begin
					case (byte_in)
						CH_NUL: begin
							res.data[0] = CH_BSL; res.data[1] = CH_NUL; res.cnt = 3'd2;
						end
						CH_LE:   begin res.data[0] = CH_ESC;   res.cnt = 3'd1; end
						CH_LT:   begin res.data[0] = CH_TAB;   res.cnt = 3'd1; end
						CH_LF_L: begin res.data[0] = CH_FF;    res.cnt = 3'd1; end
						CH_LR:   begin res.data[0] = CH_CR;    res.cnt = 3'd1; end
						CH_LN:   begin res.data[0] = CH_LF;    res.cnt = 3'd1; end
						CH_LB:   begin res.data[0] = CH_SPACE; res.cnt = 3'd1; end
						CH_BSL:  begin res.data[0] = CH_BSL;   res.cnt = 3'd1; end
						CH_STAR, CH_QMARK, CH_LBRK: begin
							res.data[0] = byte_in | HIGH_BIT; res.cnt = 3'd1;
						end
						default: begin
							if (!is_octal(byte_in)) begin
								// Literal backslash, then the byte as plain text unless it is a caret
								res.data[0] = CH_BSL;
								res.data[1] = byte_in;
								res.cnt     = (byte_in == CH_CARET) ? 3'd1 : 3'd2;
							end
						end
					endcase
				end
				PH_OCT: begin
					if (is_octal(byte_in) && cur.ocnt == 2'd1) begin
						res.cnt = 3'd0;
					end else if (is_octal(byte_in)) begin
						// Third digit closes the value
						res.data[0] = oct_acc;
						res.cnt     = (oct_acc != 8'd0) ? 3'd1 : 3'd0;
					end else if (cur.oval != 8'd0) begin
						res.data[0] = cur.oval;
						res.data[1] = byte_in;
						res.cnt     = (byte_in == CH_BSL || byte_in == CH_CARET) ? 3'd1 : 3'd2;
					end else begin
						res.data[0] = byte_in;
						res.cnt     = (byte_in == CH_BSL || byte_in == CH_CARET) ? 3'd0 : 3'd1;
					end
				end
				PH_CARET: begin
					if (byte_in == CH_NUL) begin
						res.data[0] = CH_CARET; res.data[1] = CH_NUL; res.cnt = 3'd2;
					end else if (is_upper) begin
						res.data[0] = up_c - CTRL_OFS; res.cnt = 3'd1;
					end else begin
						res.data[0] = CH_CARET; res.data[1] = byte_in; res.cnt = 3'd2;
					end
				end
				default: res.cnt = 3'd0;
			endcase
		end
	end

endmodule

[rtl/escc_emit.sv]
// Result buffer: holds the bytes of one translated input and sends them one beat
// per cycle while m_tready is high. Depends on escc_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module escc_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  escc_pkg::res_t res,
	output logic           room,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,  // [7:0] out_byte
	output logic           m_tlast   // last_of_run
);
	import escc_pkg::*;

	logic [MaxRes-1:0][7:0] buf_q;
	logic [2:0]             left_q;
	logic [1:0]             pos_q;
	logic                   take;

	assign m_tvalid = left_q != 3'd0;
	assign m_tlast  = left_q == 3'd1;
	assign m_tdata  = buf_q[pos_q];
	assign take     = m_tvalid && m_tready;
	// Accept new work when empty or when the final beat leaves this cycle
	assign room     = (left_q == 3'd0) || (m_tlast && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 3'd0;
			pos_q  <= 2'd0;
		end else if (load) begin
			left_q <= res.cnt;
			pos_q  <= 2'd0;
		end else if (take) begin
			left_q <= left_q - 3'd1;
			pos_q  <= pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res.data;
		end
	end

	`include "assert_macros.svh"

	`ESCC_ASSERT_ALWAYS(a_left_range, left_q <= 3'd4)
	`ESCC_ASSERT_ALWAYS(a_no_load_busy, !load || room)
	`ESCC_ASSERT_NEXT(a_load_shows, load && res.cnt != 3'd0, m_tvalid && pos_q == 2'd0)

endmodule

[rtl/escape_sequence_codec_core.sv]
// Escape sequence codec, top level: state and mode registers, translator, result buffer.
// Depends on escc_pkg, escc_xlate and escc_emit.
//
// Input channel s_*: one source byte per beat, 0 ends a string and flushes.
// Output channel m_*: one produced byte per beat; m_tlast marks the final
// byte caused by one input byte. An input that produces nothing yields no beat.
// cfg_we/cfg_wdata write the direction bit (0 decode, 1 encode); write only
// while the stream is idle.
// An accepted byte is translated in the same cycle and its bytes appear on
// m_* from the next cycle, one per cycle while m_tready is high.
// Throughput: one input per cycle while each input yields at most one byte and
// m_tready is high; an input that yields several bytes holds the result buffer until
// all are taken, and s_tready rises again in the cycle its last byte is taken.
// When m_tready is low the buffer holds and s_tready drops once the buffer
// is busy; nothing is lost.
// Reset clears the decode state, the high byte flag, the direction (decode)
// and empties the result buffer.
`timescale 1ns / 1ps

module escape_sequence_codec_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // last_of_run
	input  logic       cfg_we,
	input  logic       cfg_wdata
);
	import escc_pkg::*;

	codec_state_t st_q;
	codec_state_t st_nxt;
	res_t         res;
	logic         dir_q;
	logic         accept;

	assign accept = s_tvalid && s_tready;

	escc_xlate u_xlate (
		.dir     (dir_q),
		.cur     (st_q),
		.byte_in (s_tdata),
		.nxt     (st_nxt),
		.res     (res)
	);

	escc_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.res      (res),
		.room     (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '{phase: PH_IDLE, oval: 8'd0, ocnt: 2'd0, hbs: 1'b0};
			dir_q <= 1'b0;
		end else begin
			if (accept) begin
				st_q <= st_nxt;
			end
			if (cfg_we) begin
				dir_q <= cfg_wdata;
			end
		end
	end

	`include "assert_macros.svh"

	`ESCC_ASSERT_NEXT(a_nul_clears, accept && s_tdata == CH_NUL,
		st_q.phase == PH_IDLE && !st_q.hbs && st_q.ocnt == 2'd0)
	`ESCC_ASSERT_ALWAYS(a_oct_count, (st_q.phase == PH_OCT) == (st_q.ocnt != 2'd0))

endmodule

[dv/tb.sv]
// Self-checking testbench for escape_sequence_codec_core: directed and random byte
// strings in both directions, checked beat by beat against an in-bench predictor.
// Depends on escc_pkg and the codec RTL only.
`timescale 1ns / 1ps

module tb;
	import escc_pkg::*;

	localparam int          CycleLimit = 200000;
	localparam int          HoldCycles = 60;
	localparam logic [7:0]  CH_ZERO    = 8'h30;
	localparam logic [7:0]  CH_UPPER_A = 8'h41;
	localparam logic [7:0]  CH_LOWER_A = 8'h61;
	localparam logic [7:0]  CTRL_MAX   = 8'd31;
	localparam logic [7:0]  LETTERS    = 8'd26;
	localparam logic        DIR_DECODE = 1'b0;
	localparam logic        DIR_ENCODE = 1'b1;

	class escape_predictor;
		typedef struct packed {
			logic [7:0] data;
			logic       last;
		} beat_t;

		logic       dir;
		phase_t     phase;
		logic [7:0] oval;
		logic [1:0] ocnt;
		logic       hbs;
		logic [7:0] run[$];
		beat_t      expected_beats[$];
		int         errors;

		function new();
			dir = DIR_DECODE;
			clear_state();
			errors = 0;
		endfunction

		function void clear_state();
			phase = PH_IDLE;
			oval = 8'd0;
			ocnt = 2'd0;
			hbs = 1'b0;
		endfunction

		function void end_string();
			run.push_back(CH_NUL);
			clear_state();
		endfunction

		function bit octal_digit(logic [7:0] b);
			return b >= CH_ZERO && b <= CH_SEVEN;
		endfunction

		function void decode_plain(logic [7:0] b);
			phase = PH_IDLE;
			if (b == CH_NUL)
				end_string();
			else if (b == CH_BSL)
				phase = PH_BSL;
			else if (b == CH_CARET)
				phase = PH_CARET;
			else
				run.push_back(b);
		endfunction

		// A gathered value whose low byte is zero yields nothing.
		function void flush_octal();
			if (oval != 8'd0)
				run.push_back(oval);
			oval = 8'd0;
			ocnt = 2'd0;
			phase = PH_IDLE;
		endfunction

		function void decode_byte(logic [7:0] b);
			logic [7:0] c;
			logic [7:0] diff;
			case (phase)
				PH_BSL: begin
					phase = PH_IDLE;
					case (b)
						CH_NUL: begin
							run.push_back(CH_BSL);
							end_string();
						end
						CH_LE:   run.push_back(CH_ESC);
						CH_LT:   run.push_back(CH_TAB);
						CH_LF_L: run.push_back(CH_FF);
						CH_LR:   run.push_back(CH_CR);
						CH_LN:   run.push_back(CH_LF);
						CH_LB:   run.push_back(CH_SPACE);
						CH_BSL:  run.push_back(CH_BSL);
						CH_STAR, CH_QMARK, CH_LBRK: run.push_back(b | HIGH_BIT);
						default: begin
							if (octal_digit(b)) begin
								oval = b - CH_ZERO;
								ocnt = 2'd1;
								phase = PH_OCT;
							end else begin
								run.push_back(CH_BSL);
								decode_plain(b);
							end
						end
					endcase
				end
				PH_OCT: begin
					if (octal_digit(b) && ocnt < 2'd3) begin
						oval = oval * 8'd8 + (b - CH_ZERO);
						ocnt = ocnt + 2'd1;
						if (ocnt == 2'd3)
							flush_octal();
					end else begin
						flush_octal();
						decode_plain(b);
					end
				end
				PH_CARET: begin
					phase = PH_IDLE;
					if (b == CH_NUL) begin
						run.push_back(CH_CARET);
						end_string();
					end else begin
						c = b;
						diff = c - CH_LOWER_A;
						if (diff < LETTERS)
							c = c - CASE_OFS;
						diff = c - CH_UPPER_A;
						if (diff < LETTERS) begin
							run.push_back(c - CTRL_OFS);
						end else begin
							run.push_back(CH_CARET);
							run.push_back(c);
						end
					end
				end
				default: decode_plain(b);
			endcase
		endfunction

		function void encode_byte(logic [7:0] b);
			logic [7:0] c;
			case (b)
				CH_NUL: end_string();
				CH_ESC: begin run.push_back(CH_BSL); run.push_back(CH_LE); end
				CH_LF:  begin run.push_back(CH_BSL); run.push_back(CH_LN); end
				CH_FF:  begin run.push_back(CH_BSL); run.push_back(CH_LF_L); end
				CH_CR:  begin run.push_back(CH_BSL); run.push_back(CH_LR); end
				CH_TAB: begin run.push_back(CH_BSL); run.push_back(CH_LT); end
				CH_BSL: begin run.push_back(CH_BSL); run.push_back(CH_BSL); end
				WC_QMARK, WC_LBRK, WC_STAR: begin
					if (hbs) begin
						run.push_back(b);
					end else begin
						run.push_back(CH_BSL);
						run.push_back({1'b0, b[6:0]});
					end
				end
				default: begin
					if (b[7] || b <= CTRL_MAX) begin
						if (b[7])
							hbs = 1'b1;
						c = b + CTRL_OFS;
						run.push_back(CH_CARET);
						run.push_back(c);
					end else if (b == CH_DEL) begin
						run.push_back(CH_BSL);
						run.push_back(CH_ONE);
						run.push_back(CH_SEVEN);
						run.push_back(CH_SEVEN);
					end else begin
						run.push_back(b);
					end
				end
			endcase
		endfunction

		function void take_source_byte(logic [7:0] b);
			beat_t e;
			run.delete();
			if (dir == DIR_ENCODE)
				encode_byte(b);
			else
				decode_byte(b);
			foreach (run[i]) begin
				e.data = run[i];
				e.last = (i == run.size() - 1);
				expected_beats.push_back(e);
			end
		endfunction

		function void check_output_beat(logic [7:0] data, logic last);
			beat_t e;
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got data %h last %b",
					$time, data, last);
				errors++;
				return;
			end
			e = expected_beats.pop_front();
			if (data !== e.data) begin
				$display("%0t: out_byte mismatch, expected %h, got %h", $time, e.data, data);
				errors++;
			end
			if (last !== e.last) begin
				$display("%0t: last_of_run mismatch, expected %b, got %b", $time, e.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       cfg_we;
	logic       cfg_wdata;

	escape_predictor codec_model = new();
	bit              steady;
	bit              hold_req;
	int              sent;
	int              cycles;

	escape_sequence_codec_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			codec_model.check_output_beat(m_tdata, m_tlast);
	end

	// Sink side: random back-pressure, plus one long hold on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
			end
			m_tready <= steady || ($urandom_range(99) >= 21);
		end
	end

	// Entered and left at a falling edge; valid stays high into the next beat.
	task automatic send_byte(input logic [7:0] b);
		while (!steady && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		codec_model.take_source_byte(b);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (codec_model.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_direction(input logic d);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		codec_model.dir = d;
		@(negedge clk);
	endtask

	task automatic send_list(input logic [7:0] seq[$]);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	function automatic logic [7:0] escape_letter();
		case ($urandom_range(9))
			0: return CH_LE;
			1: return CH_LT;
			2: return CH_LF_L;
			3: return CH_LR;
			4: return CH_LN;
			5: return CH_LB;
			6: return CH_BSL;
			7: return CH_STAR;
			8: return CH_QMARK;
			default: return CH_LBRK;
		endcase
	endfunction

	// One well-formed decode token with random content, or some noise.
	task automatic decode_token();
		logic [7:0] b;
		int         kind;
		int         ndig;
		kind = $urandom_range(99);
		if (kind < 25) begin
			do b = 8'($urandom_range(255, 1)); while (b == CH_BSL || b == CH_CARET);
			send_byte(b);
		end else if (kind < 45) begin
			send_byte(CH_BSL);
			send_byte(escape_letter());
		end else if (kind < 60) begin
			send_byte(CH_BSL);
			ndig = $urandom_range(3, 1);
			repeat (ndig) send_byte(CH_ZERO + 8'($urandom_range(7)));
		end else if (kind < 72) begin
			send_byte(CH_CARET);
			send_byte(($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A)
				+ 8'($urandom_range(25)));
		end else if (kind < 78) begin
			send_byte(CH_CARET);
			send_byte(8'($urandom_range(255, 1)));
		end else if (kind < 84) begin
			send_byte(CH_BSL);
			send_byte(8'($urandom_range(255, 1)));
		end else if (kind < 92) begin
			send_byte(CH_NUL);
		end else begin
			send_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic encode_token();
		int kind;
		kind = $urandom_range(99);
		if (kind < 8) begin
			send_byte(CH_NUL);
		end else if (kind < 38) begin
			case ($urandom_range(8))
				0: send_byte(CH_ESC);
				1: send_byte(CH_LF);
				2: send_byte(CH_FF);
				3: send_byte(CH_CR);
				4: send_byte(CH_TAB);
				5: send_byte(CH_BSL);
				6: send_byte(CH_DEL);
				7: send_byte(WC_QMARK);
				default: send_byte($urandom_range(1) ? WC_LBRK : WC_STAR);
			endcase
		end else if (kind < 48) begin
			send_byte(8'($urandom_range(255, 128)));
		end else begin
			send_byte(8'($urandom_range(255)));
		end
	endtask

	initial begin
		int goal;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		steady = 1'b0;
		hold_req = 1'b0;
		sent = 0;
		cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_direction(DIR_DECODE);
		// escapes, zero-valued octal cut by third digit, octal cut by a non-digit,
		// caret letter and non-letter, unknown escape, escape and caret before end
		send_list('{CH_BSL, CH_LE, CH_BSL, CH_STAR,
			CH_BSL, CH_ZERO + 8'd4, CH_ZERO, CH_ZERO,
			CH_BSL, CH_SEVEN, 8'h78,
			CH_CARET, CH_LOWER_A, CH_CARET, CH_ONE,
			CH_BSL, 8'h71, CH_BSL, CH_NUL,
			CH_CARET, CH_NUL, 8'hFF, CH_NUL});

		set_direction(DIR_ENCODE);
		// marked wildcard escaped first, raw once a high byte went by
		send_list('{CH_ESC, WC_LBRK, HIGH_BIT, WC_QMARK, CH_DEL, 8'h01, CH_BSL, CH_NUL});

		// long sink hold while the source keeps offering four-beat expansions
		hold_req = 1'b1;
		repeat (12) send_byte(CH_DEL);
		drain();

		for (int p = 0; p < 8; p++) begin
			set_direction(p[0] ? DIR_ENCODE : DIR_DECODE);
			steady = (p == 3 || p == 4);
			goal = sent + 47;
			while (sent < goal) begin
				if (p[0])
					encode_token();
				else
					decode_token();
			end
		end
		steady = 1'b0;
		drain();
		repeat (8) @(negedge clk);

		if (codec_model.errors == 0 && codec_model.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
